[hw/rtl/uhid_pkg.sv]
// Shared types and constants for the HID control request handler.
// Used by the front decoder, the command queue and the back emitter.
`timescale 1ns / 1ps
`default_nettype none
package uhid_pkg;

  localparam logic [9:0] IdleDefault = 10'd500;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_REPORT = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_STALL  = 3'd3,
    KIND_FETCH  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    DEV_DEFAULT    = 3'b001,
    DEV_ADDRESSED  = 3'b010,
    DEV_CONFIGURED = 3'b100
  } dev_state_e;

  localparam logic [1:0] OpSetup  = 2'd0;
  localparam logic [1:0] OpFrame  = 2'd1;
  localparam logic [1:0] OpReport = 2'd2;

  localparam logic [1:0] RegDevLen = 2'd0;
  localparam logic [1:0] RegCfgLen = 2'd1;
  localparam logic [1:0] RegHidLen = 2'd2;
  localparam logic [1:0] RegRptLen = 2'd3;

  // bmRequestType values
  localparam logic [7:0] RtInStdDev  = 8'h80;
  localparam logic [7:0] RtInStdIf   = 8'h81;
  localparam logic [7:0] RtInStdEp   = 8'h82;
  localparam logic [7:0] RtOutStdDev = 8'h00;
  localparam logic [7:0] RtOutStdIf  = 8'h01;
  localparam logic [7:0] RtOutStdEp  = 8'h02;
  localparam logic [7:0] RtInClsIf   = 8'hA1;
  localparam logic [7:0] RtOutClsIf  = 8'h21;

  // standard bRequest codes
  localparam logic [7:0] ReqGetStatus     = 8'd0;
  localparam logic [7:0] ReqClearFeature  = 8'd1;
  localparam logic [7:0] ReqSetFeature    = 8'd3;
  localparam logic [7:0] ReqSetAddress    = 8'd5;
  localparam logic [7:0] ReqGetDescriptor = 8'd6;
  localparam logic [7:0] ReqGetConfig     = 8'd8;
  localparam logic [7:0] ReqSetConfig     = 8'd9;
  localparam logic [7:0] ReqGetInterface  = 8'd10;

  // HID class bRequest codes
  localparam logic [7:0] HidGetReport   = 8'd1;
  localparam logic [7:0] HidGetIdle     = 8'd2;
  localparam logic [7:0] HidGetProtocol = 8'd3;
  localparam logic [7:0] HidSetReport   = 8'd9;
  localparam logic [7:0] HidSetIdle     = 8'd10;
  localparam logic [7:0] HidSetProtocol = 8'd11;

  // descriptor types in the wValue high byte
  localparam logic [7:0] DescDevice = 8'h01;
  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [7:0] DescHid    = 8'h21;
  localparam logic [7:0] DescReport = 8'h22;

  localparam logic [1:0] SelDevice = 2'd0;
  localparam logic [1:0] SelConfig = 2'd1;
  localparam logic [1:0] SelHid    = 2'd2;
  localparam logic [1:0] SelReport = 2'd3;

  // One command for the back part: up to nine beats, taken from a byte list.
  typedef struct packed {
    logic [3:0]      count;    // number of beats, 1..9
    logic            is_ack;   // final beat is an ack (control data stream)
    kind_e           kind;     // kind of the non-ack beats
    logic [8:0][7:0] bytes;
    logic [1:0]      sel;
    logic [7:0]      flen;
    logic [6:0]      addr;
    logic            addr_en;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/uhid_front.sv]
// Front part: accepts items, updates device state, builds at most one command each.
// Depends on uhid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uhid_front import uhid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        take_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] request_value_i,
  input  wire logic [15:0] request_length_i,
  input  wire logic [7:0]  modifier_bits_i,
  input  wire logic [47:0] key_codes_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o
);
  logic [3:0][7:0] len_q;
  dev_state_e dstate_q, dstate_d;
  logic [6:0] addr_q, addr_d;
  logic aen_q, aen_d, cfgv_q, cfgv_d, proto_q, proto_d;
  logic [9:0] idur_q, idur_d, irem_q, irem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= {8'd45, 8'd9, 8'd34, 8'd18};
      dstate_q <= DEV_DEFAULT; addr_q <= '0; aen_q <= 1'b0; cfgv_q <= 1'b0;
      proto_q <= 1'b1; idur_q <= IdleDefault; irem_q <= '0;
    end else begin
      if (cfg_we_i) len_q[cfg_index_i] <= cfg_data_i;
      if (take_i) begin
        dstate_q <= dstate_d; addr_q <= addr_d; aen_q <= aen_d; cfgv_q <= cfgv_d;
        proto_q <= proto_d; idur_q <= idur_d; irem_q <= irem_d;
      end
    end
  end

  logic [7:0] dlen, letter, low;
  logic dok;
  cmd_t c;

  always_comb begin
    dstate_d = dstate_q; addr_d = addr_q; aen_d = aen_q; cfgv_d = cfgv_q;
    proto_d = proto_q; idur_d = idur_q; irem_d = irem_q;
    c = '0; c.kind = KIND_DATA;
    cmd_valid_o = 1'b0;
    dlen = '0; dok = 1'b1;
    low = request_value_i[7:0];
    letter = (dstate_q == DEV_CONFIGURED) ? 8'h06 :
             ((dstate_q == DEV_ADDRESSED) ? 8'h04 : 8'h07);
    c.sel = SelDevice;
    unique case (request_value_i[15:8])
      DescDevice: dlen = len_q[RegDevLen];
      DescConfig: begin c.sel = SelConfig; dlen = len_q[RegCfgLen]; end
      DescHid:    begin c.sel = SelHid; dlen = len_q[RegHidLen]; end
      DescReport: begin c.sel = SelReport; dlen = len_q[RegRptLen]; end
      default:    dok = 1'b0;
    endcase
    if (operation_i == OpSetup) begin
      cmd_valid_o = 1'b1;
      c.count = 4'd1; c.is_ack = 1'b1;
      if (request_code_i == HidGetReport && request_type_i == RtInClsIf) begin
        c.count = 4'd9; c.bytes[2] = letter; c.bytes[3] = letter;
      end else if (request_code_i == HidGetIdle && request_type_i == RtInClsIf) begin
        c.count = 4'd2; c.bytes[0] = irem_q[9:2];
      end else if (request_code_i == HidGetProtocol && request_type_i == RtInClsIf) begin
        c.count = 4'd2; c.bytes[0] = {7'd0, proto_q};
      end else if (request_code_i == HidSetReport && request_type_i == RtOutClsIf) begin
      end else if (request_code_i == HidSetIdle && request_type_i == RtOutClsIf) begin
        idur_d = {request_value_i[15:8], 2'b00};
      end else if (request_code_i == HidSetProtocol && request_type_i == RtOutClsIf) begin
        proto_d = (request_value_i == 16'd1);
      end else if (request_code_i == ReqGetStatus && (request_type_i == RtInStdDev ||
                   request_type_i == RtInStdIf || request_type_i == RtInStdEp)) begin
        c.count = 4'd3;
      end else if ((request_code_i == ReqClearFeature || request_code_i == ReqSetFeature) &&
                   (request_type_i == RtOutStdDev || request_type_i == RtOutStdIf ||
                    request_type_i == RtOutStdEp)) begin
      end else if (request_code_i == ReqSetAddress && request_type_i == RtOutStdDev) begin
        addr_d = request_value_i[6:0]; aen_d = 1'b1; dstate_d = DEV_ADDRESSED;
      end else if (request_code_i == ReqGetDescriptor && dok &&
                   (request_type_i == RtInStdDev || request_type_i == RtInStdIf)) begin
        c.is_ack = 1'b0; c.kind = KIND_FETCH;
        c.flen = (request_length_i < {8'd0, dlen}) ? request_length_i[7:0] : dlen;
      end else if (request_code_i == ReqGetConfig && request_type_i == RtInStdDev &&
                   low <= 8'd1) begin
        c.count = 4'd2; c.bytes[0] = {7'd0, cfgv_q};
      end else if (request_code_i == ReqSetConfig && request_type_i == RtOutStdDev &&
                   low <= 8'd1) begin
        cfgv_d = low[0];
        if (dstate_q == DEV_ADDRESSED) dstate_d = DEV_CONFIGURED;
        idur_d = IdleDefault; irem_d = '0;
      end else if (request_code_i == ReqGetInterface && request_type_i == RtInStdIf) begin
        c.count = 4'd2;
      end else begin
        c.is_ack = 1'b0; c.kind = KIND_STALL;
      end
    end else if (operation_i == OpFrame) begin
      if (irem_q != '0) irem_d = irem_q - 10'd1;
    end else if (operation_i == OpReport) begin
      if (dstate_q == DEV_CONFIGURED && irem_q == '0) begin
        cmd_valid_o = 1'b1;
        c.count = 4'd8; c.kind = KIND_REPORT;
        c.bytes[0] = modifier_bits_i; c.bytes[1] = idur_q[9:2];
        for (int i = 0; i < 6; i++) c.bytes[i+2] = key_codes_i[8*i +: 8];
        irem_d = idur_q;
      end
    end
    if (c.kind != KIND_FETCH) c.sel = SelDevice;
    c.addr = addr_d; c.addr_en = aen_d;
    cmd_o = c;
  end
endmodule
`default_nettype wire

[hw/rtl/uhid_queue.sv]
// Two-entry command queue between front and back.
// Depends on uhid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uhid_queue import uhid_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o
);
  cmd_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
endmodule
`default_nettype wire

[hw/rtl/uhid_back.sv]
// Back part: walks one command, one result beat a cycle while not stalled, into an output register.
// Depends on uhid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uhid_back import uhid_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cmd_t       cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] descriptor_select_o,
  output logic [7:0] fetch_length_o,
  output logic [6:0] device_address_o,
  output logic       address_enabled_o,
  output logic       last_o
);
  logic [3:0] idx_q;
  logic load, fin;
  logic [3:0] idx_n;

  assign load  = cmd_valid_i && (!out_valid_o || !out_stall_i);
  assign idx_n = idx_q + 4'd1;
  assign fin   = (idx_n == cmd_i.count);
  assign pop_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0; idx_q <= '0;
    end else begin
      if (load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (load) idx_q <= fin ? 4'd0 : idx_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o <= (fin && cmd_i.is_ack) ? KIND_ACK : cmd_i.kind;
      data_byte_o <= (fin && cmd_i.is_ack) ? 8'd0 : cmd_i.bytes[idx_q];
      descriptor_select_o <= cmd_i.sel;
      fetch_length_o <= cmd_i.flen;
      device_address_o <= cmd_i.addr;
      address_enabled_o <= cmd_i.addr_en;
      last_o <= fin;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/usb_hid_control_request_handler_core.sv]
// Channel   dir  handshake            payload
// in        in   in_valid/in_stall    operation .. key_codes
// out       out  out_valid/out_stall  kind .. last
// cfg       in   cfg_we_i             cfg_index_i, cfg_data_i
// A new item is taken each cycle while the two-entry command queue has room.
// Results leave one beat a cycle from the output register while out_stall is low,
// up to nine per item, as set by the beat count of its command.
// Reset restores state and descriptor lengths; no clearing pass.
// Output stall holds the register; queue-full stalls the input side.
`timescale 1ns / 1ps
`default_nettype none
module usb_hid_control_request_handler_core import uhid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] request_value_i,
  input  wire logic [15:0] request_length_i,
  input  wire logic [7:0]  modifier_bits_i,
  input  wire logic [47:0] key_codes_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       descriptor_select_o,
  output logic [7:0]       fetch_length_o,
  output logic [6:0]       device_address_o,
  output logic             address_enabled_o,
  output logic             last_o
);
  cmd_t f_cmd, q_head;
  logic f_valid, full, empty, pop, take;

  assign in_stall = full;
  assign take = in_valid && !full;

  uhid_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .take_i(take), .operation_i, .request_type_i, .request_code_i, .request_value_i,
    .request_length_i, .modifier_bits_i, .key_codes_i,
    .cmd_o(f_cmd), .cmd_valid_o(f_valid)
  );

  uhid_queue u_queue (
    .clk_i, .rst_ni, .push_i(take && f_valid), .push_cmd_i(f_cmd), .full_o(full),
    .pop_i(pop), .head_o(q_head), .empty_o(empty)
  );

  uhid_back u_back (
    .clk_i, .rst_ni, .cmd_i(q_head), .cmd_valid_i(!empty), .pop_o(pop),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .kind_o, .data_byte_o,
    .descriptor_select_o, .fetch_length_o, .device_address_o, .address_enabled_o, .last_o
  );

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(last_o))
    else $error("output beat changed while stalled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_fetch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (kind_o == KIND_FETCH || kind_o == KIND_STALL) |-> last_o)
    else $error("fetch or stall not last");
`endif
endmodule
`default_nettype wire
